// File: rtl/core/pdh_pkg.sv
// package: constants, codes and types shared by the density-of-states histogram core
`default_nettype none
package pdh_pkg;
	localparam int NUM_SITES_DEF = 8;
	localparam int NUM_BINS_DEF = 1024;

	localparam int OP_W = 2;
	localparam int OMEGA_W = 40;
	localparam int QW_W = 16;
	localparam int SITE_W = 3;
	localparam int POL_W = 17;
	localparam int BIDX_W = 10;
	localparam int DENS_W = 32;
	localparam int STATUS_W = 2;
	localparam int ACC_W = 48;
	localparam int BW_W = 24;
	localparam int ACT_W = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 24;

	localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
	localparam logic [OP_W-1:0] OP_ACCUM = 2'd1;
	localparam logic [OP_W-1:0] OP_READ = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OUT_OF_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_SUM_ZERO = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_BIN_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_SITES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_USE_POL = 2'd2;

	localparam logic [BW_W-1:0] BIN_WIDTH_RST = 24'd65536;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_SQRT,
		S_BDIV,
		S_ACC_RD,
		S_ACC_WR,
		S_RD_ADDR,
		S_RD_MLO,
		S_RD_MHI,
		S_RD_DEN,
		S_RD_CHK,
		S_RD_DIV,
		S_RD_NEXT,
		S_TOT,
		S_DONE
	} state_t;
endpackage
`default_nettype wire

// File: rtl/core/pdh_ifs.sv
// interfaces: request, result and configuration channels
`default_nettype none
interface pdh_in_if import pdh_pkg::*;;
	logic valid;
	logic ready;
	logic [OP_W-1:0] operation;
	logic signed [OMEGA_W-1:0] omega_sq;
	logic [QW_W-1:0] q_weight;
	logic [SITE_W-1:0] site;
	logic [POL_W-1:0] pol_mag_sq;
	logic [BIDX_W-1:0] bin_index;
	modport source (output valid, operation, omega_sq, q_weight, site, pol_mag_sq, bin_index,
		input ready);
	modport sink (input valid, operation, omega_sq, q_weight, site, pol_mag_sq, bin_index,
		output ready);
endinterface

interface pdh_out_if import pdh_pkg::*;;
	logic valid;
	logic ready;
	logic [DENS_W-1:0] partial_density;
	logic [DENS_W-1:0] total_density;
	logic [STATUS_W-1:0] status;
	modport source (output valid, partial_density, total_density, status, input ready);
	modport sink (input valid, partial_density, total_density, status, output ready);
endinterface

interface pdh_cfg_if import pdh_pkg::*;;
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/partial_dos_histogram_core.sv
// top level: per-site phonon density-of-states histogram core
// One request at a time. A clear request sweeps the bin memory, one entry per
// cycle, over all NUM_SITES*2^clog2(NUM_BINS) entries; the same sweep runs after
// reset (8192 entries at the defaults) before the first request is taken.
// Accumulate runs 28 square-root steps, 30 bin division steps and a
// read-modify-write of one memory entry. For a read with A active sites, each
// site costs a memory read, a split bin-width multiply and a 32-step division
// (skipped when the site sum is zero or the quotient saturates), the read site
// is taken once more, and the site average is a 36-step division. A finished result
// waits in an output register while the next request is accepted.
`default_nettype none
module partial_dos_histogram_core import pdh_pkg::*; #(
	parameter int NUM_SITES = NUM_SITES_DEF,
	parameter int NUM_BINS = NUM_BINS_DEF
) (
	input logic clk,
	input logic arst_n,
	pdh_cfg_if.sink cfg_ch,
	pdh_in_if.sink in_ch,
	pdh_out_if.source out_ch
);
	localparam int SW = (NUM_SITES > 1) ? $clog2(NUM_SITES) : 1;
	localparam int BW = $clog2(NUM_BINS);
	localparam int AW = SW + BW;
	localparam int DEPTH = NUM_SITES * (2 ** BW);

	state_t state_q, state_d;

	logic [BW_W-1:0] bin_width_q;
	logic [ACT_W-1:0] active_q;
	logic use_pol_q;

	logic [ACC_W-1:0] mem [DEPTH];
	logic [ACC_W-1:0] rdata_q;
	logic mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [ACC_W-1:0] mem_wdata;

	logic [ACC_W-1:0] sums_q [NUM_SITES];
	logic [AW-1:0] sweep_q;
	logic clr_res_q;

	logic [OP_W-1:0] op_q;
	logic [SITE_W-1:0] site_q;
	logic [BIDX_W-1:0] bidx_q;
	logic [QW_W-1:0] qw_q;
	logic [32:0] prod_q;
	logic [5:0] cnt_q;
	logic [55:0] xq_q;
	logic [29:0] srem_q;
	logic [27:0] root_q;
	logic [29:0] bdq_q;
	logic [24:0] brem_q;
	logic [17:0] wt_q;
	logic [AW-1:0] addr_q;
	logic [ACC_W-1:0] sum_q, num_q, pl_q, ph_q;
	logic [71:0] den_q, drem_q;
	logic [DENS_W-1:0] dq_q, partial_q;
	logic [ACT_W-1:0] s_q, a_q, trem_q;
	logic last_q;
	logic [35:0] acc_q;
	logic [STATUS_W-1:0] status_q;

	logic out_valid_q;
	logic [DENS_W-1:0] out_partial_q, out_total_q;
	logic [STATUS_W-1:0] out_status_q;

	logic [BW_W-1:0] w;
	logic [29:0] sq_remn, sq_trial;
	logic sq_ge;
	logic [27:0] root_n;
	logic [25:0] bd_r2, bd_den;
	logic bd_ge;
	logic bin_big, site_ok, a_last, chk_zero, chk_sat, rd_ge, t_ge, out_free, in_acc;
	logic [SW-1:0] cur_site;
	logic [72:0] rd_r2;
	logic [ACT_W:0] t_r2;
	logic [ACC_W:0] acc_sum, site_sum;
	logic [ACC_W-1:0] acc_sat, site_sat;
	logic [ACT_W-1:0] a_clamp;
	logic [38:0] mag;

	assign w = (bin_width_q == '0) ? BW_W'(1) : bin_width_q;
	assign sq_remn = {srem_q[27:0], xq_q[55:54]};
	assign sq_trial = {root_q, 2'b01};
	assign sq_ge = sq_remn >= sq_trial;
	assign root_n = {root_q[26:0], sq_ge};
	assign bd_r2 = {brem_q, bdq_q[29]};
	assign bd_den = {1'b0, w, 1'b0};
	assign bd_ge = bd_r2 >= bd_den;
	assign bin_big = 32'(bdq_q) >= NUM_BINS;
	assign site_ok = 32'(site_q) < NUM_SITES;
	assign a_last = s_q == (a_q - ACT_W'(1));
	assign cur_site = last_q ? SW'(site_q) : SW'(s_q);
	assign chk_zero = sum_q == '0;
	assign chk_sat = {24'b0, num_q} >= den_q;
	assign rd_r2 = {drem_q, 1'b0};
	assign rd_ge = rd_r2 >= {1'b0, den_q};
	assign t_r2 = {trem_q, acc_q[35]};
	assign t_ge = t_r2 >= {1'b0, a_q};
	assign out_free = !out_valid_q || out_ch.ready;
	assign in_acc = in_ch.valid && in_ch.ready;
	assign acc_sum = {1'b0, rdata_q} + (ACC_W+1)'(wt_q);
	assign acc_sat = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
	assign site_sum = {1'b0, sums_q[SW'(site_q)]} + (ACC_W+1)'(wt_q);
	assign site_sat = site_sum[ACC_W] ? '1 : site_sum[ACC_W-1:0];
	assign mag = in_ch.omega_sq[39] ? '0 : in_ch.omega_sq[38:0];

	always_comb begin
		if (active_q == '0) begin
			a_clamp = ACT_W'(1);
		end else if (32'(active_q) > NUM_SITES) begin
			a_clamp = ACT_W'(NUM_SITES);
		end else begin
			a_clamp = active_q;
		end
	end

	assign cfg_ch.ready = 1'b1;
	assign out_ch.valid = out_valid_q;
	assign out_ch.partial_density = out_partial_q;
	assign out_ch.total_density = out_total_q;
	assign out_ch.status = out_status_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (sweep_q == AW'(DEPTH - 1)) state_d = clr_res_q ? S_DONE : S_IDLE;
			end
			S_IDLE: begin
				if (in_acc) begin
					case (in_ch.operation)
						OP_CLEAR: state_d = S_CLEAR;
						OP_ACCUM: state_d = S_SQRT;
						OP_READ: state_d = (32'(in_ch.bin_index) >= NUM_BINS) ? S_DONE : S_RD_ADDR;
						default: state_d = S_DONE;
					endcase
				end
			end
			S_SQRT: if (cnt_q == '0) state_d = S_BDIV;
			S_BDIV: if (cnt_q == '0) state_d = S_ACC_RD;
			S_ACC_RD: state_d = (bin_big || !site_ok) ? S_DONE : S_ACC_WR;
			S_ACC_WR: state_d = S_DONE;
			S_RD_ADDR: state_d = S_RD_MLO;
			S_RD_MLO: state_d = S_RD_MHI;
			S_RD_MHI: state_d = S_RD_DEN;
			S_RD_DEN: state_d = S_RD_CHK;
			S_RD_CHK: state_d = (chk_zero || chk_sat) ? S_RD_NEXT : S_RD_DIV;
			S_RD_DIV: if (cnt_q == '0) state_d = S_RD_NEXT;
			S_RD_NEXT: begin
				if (last_q || (a_last && !site_ok)) state_d = S_TOT;
				else state_d = S_RD_ADDR;
			end
			S_TOT: if (cnt_q == '0) state_d = S_DONE;
			S_DONE: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ch.ready = state_q == S_IDLE;
		mem_we = 1'b0;
		mem_waddr = sweep_q;
		mem_wdata = '0;
		mem_re = 1'b0;
		mem_raddr = {SW'(site_q), BW'(bdq_q)};
		case (state_q)
			S_CLEAR: mem_we = 1'b1;
			S_ACC_RD: mem_re = 1'b1;
			S_ACC_WR: begin
				mem_we = 1'b1;
				mem_waddr = addr_q;
				mem_wdata = acc_sat;
			end
			S_RD_ADDR: begin
				mem_re = 1'b1;
				mem_raddr = {cur_site, BW'(bidx_q)};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (mem_re) rdata_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			sweep_q <= '0;
			clr_res_q <= 1'b0;
			out_valid_q <= 1'b0;
			bin_width_q <= BIN_WIDTH_RST;
			active_q <= ACT_W'(1);
			use_pol_q <= 1'b1;
			for (int i = 0; i < NUM_SITES; i++) sums_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_ch.valid) begin
				case (cfg_ch.index)
					REG_BIN_WIDTH: bin_width_q <= cfg_ch.data;
					REG_ACTIVE_SITES: active_q <= cfg_ch.data[ACT_W-1:0];
					REG_USE_POL: use_pol_q <= cfg_ch.data[0];
					default: ;
				endcase
			end
			if (state_q == S_CLEAR) sweep_q <= sweep_q + AW'(1);
			if (state_q == S_IDLE && in_acc && in_ch.operation == OP_CLEAR) begin
				sweep_q <= '0;
				clr_res_q <= 1'b1;
				for (int i = 0; i < NUM_SITES; i++) sums_q[i] <= '0;
			end
			if (state_q == S_ACC_WR) sums_q[SW'(site_q)] <= site_sat;
			if (state_q == S_DONE && out_free) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					op_q <= in_ch.operation;
					site_q <= in_ch.site;
					bidx_q <= in_ch.bin_index;
					qw_q <= in_ch.q_weight;
					prod_q <= in_ch.q_weight * in_ch.pol_mag_sq;
					xq_q <= {1'b0, mag, 16'b0};
					srem_q <= '0;
					root_q <= '0;
					cnt_q <= 6'd27;
					partial_q <= '0;
					acc_q <= '0;
					s_q <= '0;
					last_q <= 1'b0;
					a_q <= a_clamp;
					status_q <= (in_ch.operation == OP_READ && 32'(in_ch.bin_index) >= NUM_BINS)
						? ST_OUT_OF_RANGE : ST_OK;
				end
			end
			S_SQRT: begin
				srem_q <= sq_ge ? sq_remn - sq_trial : sq_remn;
				root_q <= root_n;
				xq_q <= {xq_q[53:0], 2'b00};
				cnt_q <= cnt_q - 6'd1;
				wt_q <= use_pol_q ? 18'((34'(prod_q) + 34'd32768) >> 16) : 18'(qw_q);
				if (cnt_q == '0) begin
					bdq_q <= 30'({root_n, 1'b0}) + 30'(w);
					brem_q <= '0;
					cnt_q <= 6'd29;
				end
			end
			S_BDIV: begin
				brem_q <= 25'(bd_ge ? bd_r2 - bd_den : bd_r2);
				bdq_q <= {bdq_q[28:0], bd_ge};
				cnt_q <= cnt_q - 6'd1;
			end
			S_ACC_RD: begin
				addr_q <= {SW'(site_q), BW'(bdq_q)};
				if (bin_big) status_q <= ST_OUT_OF_RANGE;
			end
			S_RD_ADDR: sum_q <= sums_q[cur_site];
			S_RD_MLO: begin
				num_q <= rdata_q;
				pl_q <= sum_q[23:0] * w;
			end
			S_RD_MHI: ph_q <= sum_q[47:24] * w;
			S_RD_DEN: den_q <= {ph_q, 24'b0} + 72'(pl_q);
			S_RD_CHK: begin
				if (chk_zero) begin
					dq_q <= '0;
				end else if (chk_sat) begin
					dq_q <= '1;
				end else begin
					drem_q <= 72'(num_q);
					dq_q <= '0;
					cnt_q <= 6'd31;
				end
			end
			S_RD_DIV: begin
				drem_q <= 72'(rd_ge ? rd_r2 - {1'b0, den_q} : rd_r2);
				dq_q <= {dq_q[30:0], rd_ge};
				cnt_q <= cnt_q - 6'd1;
			end
			S_RD_NEXT: begin
				cnt_q <= 6'd35;
				trem_q <= '0;
				if (last_q) begin
					partial_q <= dq_q;
					status_q <= chk_zero ? ST_SUM_ZERO : ST_OK;
				end else begin
					acc_q <= acc_q + 36'(dq_q);
					if (a_last) begin
						last_q <= 1'b1;
						if (!site_ok) status_q <= ST_SUM_ZERO;
					end else begin
						s_q <= s_q + ACT_W'(1);
					end
				end
			end
			S_TOT: begin
				trem_q <= ACT_W'(t_ge ? t_r2 - {1'b0, a_q} : t_r2);
				acc_q <= {acc_q[34:0], t_ge};
				cnt_q <= cnt_q - 6'd1;
			end
			S_DONE: begin
				if (out_free) begin
					out_partial_q <= (op_q == OP_READ) ? partial_q : '0;
					out_total_q <= (op_q == OP_READ) ? acc_q[31:0] : '0;
					out_status_q <= (op_q == OP_READ || op_q == OP_ACCUM) ? status_q : ST_OK;
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// File: tb/partial_dos_histogram_core_test.sv
// testbench: random and directed requests against a bit-exact density-of-states histogram predictor
`default_nettype none
module partial_dos_histogram_core_test import pdh_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSITE = NUM_SITES_DEF;
	localparam int NBIN = NUM_BINS_DEF;
	localparam int STALL_LIMIT = 40000;
	localparam logic [47:0] ACC_SAT = 48'hFFFF_FFFF_FFFF;
	localparam logic [31:0] DENS_SAT = 32'hFFFF_FFFF;
	localparam logic [OP_W-1:0] OP_NONE = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0] operation;
		logic signed [OMEGA_W-1:0] omega_sq;
		logic [QW_W-1:0] q_weight;
		logic [SITE_W-1:0] site;
		logic [POL_W-1:0] pol_mag_sq;
		logic [BIDX_W-1:0] bin_index;
	} dos_req_t;

	typedef struct packed {
		logic [DENS_W-1:0] partial_density;
		logic [DENS_W-1:0] total_density;
		logic [STATUS_W-1:0] status;
	} dos_res_t;

	logic clk;
	logic arst_n;

	pdh_cfg_if cfg_ch();
	pdh_in_if in_ch();
	pdh_out_if out_ch();

	partial_dos_histogram_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_ch(cfg_ch.sink),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	// shadow histogram state and registers
	logic [ACC_W-1:0] bins_sh [NSITE*NBIN];
	logic [ACC_W-1:0] sums_sh [NSITE];
	logic [BW_W-1:0] width_sh;
	logic [ACT_W-1:0] active_sh;
	logic pol_en_sh;

	dos_req_t pending_reqs[$];
	dos_res_t expected_res[$];
	int errors;
	int sender_idle;
	int recv_stall;
	bit hold_req;
	bit hold_seen;
	int hold_cnt;
	bit in_fire;
	int quiet_cycles;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	task automatic report(input string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	function automatic logic [63:0] int_sqrt(input logic [63:0] x);
		logic [63:0] root;
		logic [63:0] bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > x) bitv >>= 2;
		while (bitv != 0) begin
			if (x >= root + bitv) begin
				x -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	function automatic logic [47:0] sat_add(input logic [47:0] a, input logic [63:0] b);
		logic [63:0] s;
		s = {16'd0, a} + b;
		return (s > {16'd0, ACC_SAT}) ? ACC_SAT : s[47:0];
	endfunction

	function automatic logic [31:0] site_dens(input int s, input int b, input logic [63:0] w);
		logic [127:0] num;
		logic [127:0] den;
		logic [127:0] q;
		if (sums_sh[s] == 0) return 0;
		num = {80'd0, bins_sh[s*NBIN+b]} << 32;
		den = {80'd0, sums_sh[s]} * {64'd0, w};
		q = num / den;
		return (q > {96'd0, DENS_SAT}) ? DENS_SAT : q[31:0];
	endfunction

	function automatic void clear_hist();
		foreach (bins_sh[i]) bins_sh[i] = 0;
		foreach (sums_sh[i]) sums_sh[i] = 0;
	endfunction

	function automatic dos_res_t predict_dos(input dos_req_t r);
		dos_res_t res;
		logic [63:0] w;
		logic [63:0] mag;
		logic [63:0] freq;
		logic [63:0] bin;
		logic [63:0] wt;
		logic [63:0] acc;
		int a;
		int k;
		res = '0;
		w = (width_sh == 0) ? 64'd1 : {40'd0, width_sh};
		case (r.operation)
			OP_CLEAR: clear_hist();
			OP_ACCUM: begin
				mag = r.omega_sq[OMEGA_W-1] ? 64'd0 : {24'd0, r.omega_sq};
				freq = int_sqrt(mag << 16);
				bin = (2 * freq + w) / (2 * w);
				wt = pol_en_sh ? (({48'd0, r.q_weight} * {47'd0, r.pol_mag_sq} + 64'd32768) >> 16)
					: {48'd0, r.q_weight};
				if (bin >= NBIN) begin
					res.status = ST_OUT_OF_RANGE;
				end else if (r.site < NSITE) begin
					k = r.site * NBIN + int'(bin);
					bins_sh[k] = sat_add(bins_sh[k], wt);
					sums_sh[r.site] = sat_add(sums_sh[r.site], wt);
				end
			end
			OP_READ: begin
				if (r.bin_index >= NBIN) begin
					res.status = ST_OUT_OF_RANGE;
				end else begin
					a = (active_sh == 0) ? 1 : int'(active_sh);
					if (a > NSITE) a = NSITE;
					if (r.site < NSITE && sums_sh[r.site] != 0)
						res.partial_density = site_dens(r.site, r.bin_index, w);
					else
						res.status = ST_SUM_ZERO;
					acc = 0;
					for (int s = 0; s < a; s++) acc += site_dens(s, r.bin_index, w);
					acc = acc / a;
					res.total_density = (acc > {32'd0, DENS_SAT}) ? DENS_SAT : acc[31:0];
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	// driver
	always @(negedge clk) begin
		dos_req_t nx;
		if (!in_ch.valid || in_fire) begin
			if (pending_reqs.size() != 0 && $urandom_range(99) >= sender_idle) begin
				nx = pending_reqs.pop_front();
				in_ch.valid <= 1'b1;
				in_ch.operation <= nx.operation;
				in_ch.omega_sq <= nx.omega_sq;
				in_ch.q_weight <= nx.q_weight;
				in_ch.site <= nx.site;
				in_ch.pol_mag_sq <= nx.pol_mag_sq;
				in_ch.bin_index <= nx.bin_index;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// receiver readiness, with a long hold-off on request
	always @(negedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_cnt = 3000;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= recv_stall);
		end
	end

	// monitor and watchdog
	always @(posedge clk) begin
		dos_req_t rq;
		dos_res_t got;
		dos_res_t want;
		in_fire = in_ch.valid && in_ch.ready && arst_n;
		if (in_fire) begin
			rq.operation = in_ch.operation;
			rq.omega_sq = in_ch.omega_sq;
			rq.q_weight = in_ch.q_weight;
			rq.site = in_ch.site;
			rq.pol_mag_sq = in_ch.pol_mag_sq;
			rq.bin_index = in_ch.bin_index;
			expected_res.push_back(predict_dos(rq));
		end
		if (out_ch.valid && out_ch.ready && arst_n) begin
			got.partial_density = out_ch.partial_density;
			got.total_density = out_ch.total_density;
			got.status = out_ch.status;
			if (expected_res.size() == 0) begin
				report("result with no request outstanding");
			end else begin
				want = expected_res.pop_front();
				if (got.partial_density !== want.partial_density)
					report($sformatf("partial_density %0h want %0h",
						got.partial_density, want.partial_density));
				if (got.total_density !== want.total_density)
					report($sformatf("total_density %0h want %0h",
						got.total_density, want.total_density));
				if (got.status !== want.status)
					report($sformatf("status %0d want %0d", got.status, want.status));
			end
		end
		if (in_fire || (out_ch.valid && out_ch.ready) || (cfg_ch.valid && cfg_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("partial_dos_histogram_core_test: errors");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		case (idx)
			REG_BIN_WIDTH: width_sh = val[BW_W-1:0];
			REG_ACTIVE_SITES: active_sh = val[ACT_W-1:0];
			REG_USE_POL: pol_en_sh = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic set_regs(input logic [BW_W-1:0] w, input logic [ACT_W-1:0] a, input bit p);
		write_reg(REG_BIN_WIDTH, w);
		write_reg(REG_ACTIVE_SITES, {20'd0, a});
		write_reg(REG_USE_POL, {23'd0, p});
	endtask

	task automatic drain();
		while (pending_reqs.size() != 0 || in_ch.valid || expected_res.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic dos_req_t make_req(input logic [OP_W-1:0] op);
		dos_req_t r;
		logic [63:0] w;
		logic [63:0] f;
		logic [63:0] om;
		int pick;
		r.operation = op;
		r.q_weight = 16'($urandom());
		r.site = 3'($urandom());
		r.pol_mag_sq = 17'($urandom_range(65536));
		r.bin_index = ($urandom_range(9) == 0) ? 10'($urandom()) : 10'($urandom_range(40));
		w = (width_sh == 0) ? 64'd1 : {40'd0, width_sh};
		pick = $urandom_range(99);
		if (pick < 10) begin
			r.omega_sq = 40'({$urandom(), $urandom()});
		end else if (pick < 15) begin
			r.omega_sq = 40'(-$signed({24'd0, $urandom_range(65535)}) - 1);
		end else begin
			f = w * $urandom_range(40) + $urandom_range(32'(w & 64'hFFFFFFFF)) - w / 2;
			if (f[63]) f = 0;
			om = (f * f) >> 16;
			r.omega_sq = (f > 64'd4_000_000_000 || om >= (64'd1 << 39)) ?
				{1'b0, 39'($urandom()) } : om[OMEGA_W-1:0];
		end
		return r;
	endfunction

	task automatic random_reqs(input int n);
		int p;
		for (int i = 0; i < n; i++) begin
			p = $urandom_range(99);
			if (p < 2) pending_reqs.push_back(make_req(OP_CLEAR));
			else if (p < 5) pending_reqs.push_back(make_req(OP_NONE));
			else if (p < 55) pending_reqs.push_back(make_req(OP_ACCUM));
			else pending_reqs.push_back(make_req(OP_READ));
		end
	endtask

	initial begin
		dos_req_t r;
		errors = 0;
		sender_idle = 0;
		recv_stall = 0;
		hold_req = 0;
		hold_seen = 0;
		hold_cnt = 0;
		in_fire = 0;
		quiet_cycles = 0;
		width_sh = BIN_WIDTH_RST;
		active_sh = 1;
		pol_en_sh = 1'b1;
		clear_hist();
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.operation = OP_CLEAR;
		in_ch.omega_sq = '0;
		in_ch.q_weight = '0;
		in_ch.site = '0;
		in_ch.pol_mag_sq = '0;
		in_ch.bin_index = '0;
		out_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_BIN_WIDTH;
		cfg_ch.data = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty reads, field extremes, every operation
		r = '0;
		r.operation = OP_READ; r.site = 3'd7; r.bin_index = 10'd1023;
		pending_reqs.push_back(r);
		r = '0;
		r.operation = OP_ACCUM; r.omega_sq = 40'sh80_0000_0000; r.q_weight = 16'hFFFF;
		r.pol_mag_sq = 17'd65536;
		pending_reqs.push_back(r);
		r.omega_sq = 40'sh7F_FFFF_FFFF; r.site = 3'd7;
		pending_reqs.push_back(r);
		r.omega_sq = 40'sd1 << 16; r.site = 3'd0; r.pol_mag_sq = 17'd1;
		pending_reqs.push_back(r);
		r.pol_mag_sq = 17'd65536; r.q_weight = 16'd1;
		pending_reqs.push_back(r);
		r.omega_sq = 40'sd4 << 16; r.q_weight = 16'hFFFF; r.site = 3'd7;
		pending_reqs.push_back(r);
		r.operation = OP_READ; r.bin_index = 10'd0; r.site = 3'd0;
		pending_reqs.push_back(r);
		r.bin_index = 10'd1; r.site = 3'd7;
		pending_reqs.push_back(r);
		r.bin_index = 10'd2; r.site = 3'd3;
		pending_reqs.push_back(r);
		r = {OP_NONE, 40'sh7F_FFFF_FFFF, 16'hFFFF, 3'd7, 17'h1FFFF, 10'h3FF};
		pending_reqs.push_back(r);
		r = '0;
		r.operation = OP_CLEAR;
		pending_reqs.push_back(r);
		r.operation = OP_READ; r.bin_index = 10'd1;
		pending_reqs.push_back(r);
		drain();

		// zero width and saturating densities
		set_regs(24'd0, 4'd0, 1'b0);
		r = '0;
		r.operation = OP_ACCUM; r.q_weight = 16'd1;
		pending_reqs.push_back(r);
		r.operation = OP_READ;
		pending_reqs.push_back(r);
		random_reqs(80);
		drain();

		set_regs(BIN_WIDTH_RST, 4'd1, 1'b1);
		random_reqs(200);
		drain();

		sender_idle = 66;
		set_regs(24'hFF_FFFF, 4'd8, 1'b0);
		random_reqs(180);
		drain();

		sender_idle = 0;
		recv_stall = 66;
		set_regs(24'd1, 4'd15, 1'b1);
		random_reqs(150);
		drain();

		sender_idle = 20;
		recv_stall = 20;
		set_regs(24'd40000, 4'd5, 1'b1);
		random_reqs(200);
		drain();

		// long receiver hold-off while requests keep coming
		sender_idle = 0;
		recv_stall = 0;
		set_regs(24'd200000, 4'd8, 1'b1);
		hold_req = 1'b1;
		random_reqs(200);
		drain();

		set_regs(24'd12345, 4'd3, 1'b0);
		sender_idle = 66;
		recv_stall = 66;
		random_reqs(120);
		drain();

		repeat (400) @(posedge clk);
		if (errors == 0)
			$display("partial_dos_histogram_core_test: clean");
		else
			$display("partial_dos_histogram_core_test: errors");
		$finish;
	end
endmodule
`default_nettype wire
